// ===== hdl/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed frame receiver package
// Widths, limits, command codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

   localparam int NUM_SLOTS    = 4;
   localparam int BUFFER_BYTES = 1048576;

   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int SLOT_W      = 2;
   localparam int LEN_W       = 21;
   localparam int OFFSET_W    = 20;
   localparam int HDR_CNT_W   = 3;
   localparam int HDR_SHIFT_W = 24;
   localparam int HDR_LEN_W   = HDR_SHIFT_W + BYTE_W;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [LEN_W-1:0]     MAX_FRAME_LEN_RESET = LEN_W'(1048576);
   localparam logic [LEN_W-1:0]     BUFFER_LIMIT        = LEN_W'(BUFFER_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST            = HDR_CNT_W'(3);
   localparam logic [HDR_CNT_W-1:0] HDR_PAYLOAD         = HDR_CNT_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FRAME_LEN   = CSR_IDX_W'(0);

   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE    = 2'd0,
      CMD_CLOSE   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic              release_en;
      logic [SLOT_W-1:0] release_idx;
      logic              mark_en;
      logic [SLOT_W-1:0] mark_idx;
   } lpfr_slot_ctrl_type;

   typedef struct packed {
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
   } lpfr_slot_stat_type;

endpackage

`default_nettype wire

// ===== hdl/lpfr_if.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed frame receiver channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpfr_req_if;
   import lpfr_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [BYTE_W-1:0]   data_byte;
   logic [SLOT_W-1:0]   release_slot;

   modport source (output valid, output cmd, output data_byte, output release_slot,
                   input ready);
   modport sink   (input valid, input cmd, input data_byte, input release_slot,
                   output ready);
endinterface

interface lpfr_rsp_if;
   import lpfr_pkg::*;

   logic                valid;
   logic                ready;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_slot;
   logic [OFFSET_W-1:0] wr_offset;
   logic [BYTE_W-1:0]   wr_data;
   logic                byte_dropped;
   logic                frame_done;
   logic [LEN_W-1:0]    frame_size;
   logic                abort;

   modport source (output valid, output wr_en, output wr_slot, output wr_offset,
                   output wr_data, output byte_dropped, output frame_done,
                   output frame_size, output abort, input ready);
   modport sink   (input valid, input wr_en, input wr_slot, input wr_offset,
                   input wr_data, input byte_dropped, input frame_done,
                   input frame_size, input abort, output ready);
endinterface

`default_nettype wire

// ===== hdl/lpfr_csr.sv =====
// ----------------------------------------------------------------------------
// Frame receiver register port
// APB-style access to the maximum frame length register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [lpfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [lpfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lpfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [lpfr_pkg::LEN_W-1:0]       max_frame_len
);
   import lpfr_pkg::*;

   logic [LEN_W-1:0]     max_frame_len_ff;
   logic [LEN_W-1:0]     max_frame_len_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == REG_MAX_FRAME_LEN);

   assign max_frame_len_in = wr_hit ? csr_pwdata[LEN_W-1:0] : max_frame_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= MAX_FRAME_LEN_RESET;
      end else begin
         max_frame_len_ff <= max_frame_len_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_MAX_FRAME_LEN) begin
         csr_prdata = CSR_DATA_W'(max_frame_len_ff);
      end
   end

   assign max_frame_len = max_frame_len_ff;

endmodule

`default_nettype wire

// ===== hdl/lpfr_slots.sv =====
// ----------------------------------------------------------------------------
// Frame receiver slot tracker
// Busy flags per slot and lowest-free-slot priority encode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_slots (
   input  wire                               clock,
   input  wire                               reset,
   input  lpfr_pkg::lpfr_slot_ctrl_type      ctrl,
   output lpfr_pkg::lpfr_slot_stat_type      stat
);
   import lpfr_pkg::*;

   logic slot_busy_ff [NUM_SLOTS];
   logic slot_busy_in [NUM_SLOTS];

   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_busy_in[k] = slot_busy_ff[k];
      end
      if (ctrl.release_en && (32'(ctrl.release_idx) < NUM_SLOTS)) begin
         slot_busy_in[ctrl.release_idx] = 1'b0;
      end
      if (ctrl.mark_en && (32'(ctrl.mark_idx) < NUM_SLOTS)) begin
         slot_busy_in[ctrl.mark_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_busy_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_busy_ff[k] <= slot_busy_in[k];
         end
      end
   end

   // lowest free slot wins
   always_comb begin
      stat.free_found = 1'b0;
      stat.free_idx   = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (!slot_busy_ff[k]) begin
            stat.free_found = 1'b1;
            stat.free_idx   = SLOT_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lpfr_core.sv =====
// ----------------------------------------------------------------------------
// Frame receiver parser
// Input register, header/payload parser state and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [lpfr_pkg::LEN_W-1:0]        max_frame_len,
   lpfr_req_if.sink                          req_chan,
   lpfr_rsp_if.source                        rsp_chan,
   output lpfr_pkg::lpfr_slot_ctrl_type      slot_ctrl,
   input  lpfr_pkg::lpfr_slot_stat_type      slot_stat
);
   import lpfr_pkg::*;

   // input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [CMD_W-1:0]      in_cmd_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic [SLOT_W-1:0]     in_rel_ff;

   // parser state
   logic [HDR_CNT_W-1:0]   header_count_ff,  header_count_in;
   logic [HDR_SHIFT_W-1:0] header_shift_ff,  header_shift_in;
   logic [LEN_W-1:0]       expected_len_ff,  expected_len_in;
   logic [LEN_W-1:0]       payload_count_ff, payload_count_in;
   logic [SLOT_W-1:0]      write_slot_ff,    write_slot_in;
   logic                   drop_frame_ff,    drop_frame_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  wr_en_ff,        wr_en_in;
   logic [SLOT_W-1:0]     wr_slot_ff,      wr_slot_in;
   logic [OFFSET_W-1:0]   wr_offset_ff,    wr_offset_in;
   logic [BYTE_W-1:0]     wr_data_ff,      wr_data_in;
   logic                  byte_dropped_ff, byte_dropped_in;
   logic                  frame_done_ff,   frame_done_in;
   logic [LEN_W-1:0]      frame_size_ff,   frame_size_in;
   logic                  abort_ff,        abort_in;

   logic                  advance;
   logic                  req_take;
   logic [HDR_LEN_W-1:0]  hdr_len;
   logic [LEN_W-1:0]      limit;
   logic                  len_bad;
   logic [LEN_W-1:0]      count_inc;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   assign hdr_len   = {header_shift_ff, in_byte_ff};
   assign limit     = (max_frame_len > BUFFER_LIMIT) ? BUFFER_LIMIT : max_frame_len;
   assign len_bad   = (hdr_len == '0) || (hdr_len > HDR_LEN_W'(limit));
   assign count_inc = payload_count_ff + LEN_W'(1);

   always_comb begin
      header_count_in  = header_count_ff;
      header_shift_in  = header_shift_ff;
      expected_len_in  = expected_len_ff;
      payload_count_in = payload_count_ff;
      write_slot_in    = write_slot_ff;
      drop_frame_in    = drop_frame_ff;
      wr_en_in         = 1'b0;
      wr_slot_in       = '0;
      wr_offset_in     = '0;
      wr_data_in       = '0;
      byte_dropped_in  = 1'b0;
      frame_done_in    = 1'b0;
      frame_size_in    = '0;
      abort_in         = 1'b0;
      slot_ctrl        = '0;

      if (advance) begin
         case (in_cmd_ff)
            CMD_CLOSE: begin
               header_count_in  = '0;
               header_shift_in  = '0;
               expected_len_in  = '0;
               payload_count_in = '0;
               write_slot_in    = '0;
               drop_frame_in    = 1'b0;
            end
            CMD_RELEASE: begin
               slot_ctrl.release_en  = 1'b1;
               slot_ctrl.release_idx = in_rel_ff;
            end
            CMD_BYTE: begin
               if (header_count_ff < HDR_LAST) begin
                  header_shift_in = {header_shift_ff[HDR_SHIFT_W-BYTE_W-1:0], in_byte_ff};
                  header_count_in = header_count_ff + HDR_CNT_W'(1);
               end else if (header_count_ff == HDR_LAST) begin
                  if (len_bad) begin
                     abort_in         = 1'b1;
                     header_count_in  = '0;
                     header_shift_in  = '0;
                     expected_len_in  = '0;
                     payload_count_in = '0;
                     write_slot_in    = '0;
                     drop_frame_in    = 1'b0;
                  end else begin
                     expected_len_in  = hdr_len[LEN_W-1:0];
                     payload_count_in = '0;
                     header_count_in  = HDR_PAYLOAD;
                     write_slot_in    = slot_stat.free_found ? slot_stat.free_idx : '0;
                     drop_frame_in    = !slot_stat.free_found;
                  end
               end else begin
                  if (drop_frame_ff) begin
                     byte_dropped_in = 1'b1;
                  end else begin
                     wr_en_in     = 1'b1;
                     wr_slot_in   = write_slot_ff;
                     wr_offset_in = payload_count_ff[OFFSET_W-1:0];
                     wr_data_in   = in_byte_ff;
                  end
                  payload_count_in = count_inc;
                  if (count_inc >= expected_len_ff) begin
                     if (!drop_frame_ff) begin
                        frame_done_in      = 1'b1;
                        frame_size_in      = expected_len_ff;
                        slot_ctrl.mark_en  = 1'b1;
                        slot_ctrl.mark_idx = write_slot_ff;
                     end
                     header_count_in  = '0;
                     header_shift_in  = '0;
                     expected_len_in  = '0;
                     payload_count_in = '0;
                     write_slot_in    = '0;
                     drop_frame_in    = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         header_count_ff  <= '0;
         header_shift_ff  <= '0;
         expected_len_ff  <= '0;
         payload_count_ff <= '0;
         write_slot_ff    <= '0;
         drop_frame_ff    <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         header_count_ff  <= header_count_in;
         header_shift_ff  <= header_shift_in;
         expected_len_ff  <= expected_len_in;
         payload_count_ff <= payload_count_in;
         write_slot_ff    <= write_slot_in;
         drop_frame_ff    <= drop_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_chan.cmd;
         in_byte_ff <= req_chan.data_byte;
         in_rel_ff  <= req_chan.release_slot;
      end
      if (advance) begin
         wr_en_ff        <= wr_en_in;
         wr_slot_ff      <= wr_slot_in;
         wr_offset_ff    <= wr_offset_in;
         wr_data_ff      <= wr_data_in;
         byte_dropped_ff <= byte_dropped_in;
         frame_done_ff   <= frame_done_in;
         frame_size_ff   <= frame_size_in;
         abort_ff        <= abort_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.wr_en        = wr_en_ff;
   assign rsp_chan.wr_slot      = wr_slot_ff;
   assign rsp_chan.wr_offset    = wr_offset_ff;
   assign rsp_chan.wr_data      = wr_data_ff;
   assign rsp_chan.byte_dropped = byte_dropped_ff;
   assign rsp_chan.frame_done   = frame_done_ff;
   assign rsp_chan.frame_size   = frame_size_ff;
   assign rsp_chan.abort        = abort_ff;

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed frame receiver
// Parses 4-byte big-endian length headers, claims a free slot per frame and
// emits payload write commands, frame completion and abort indications.
//
//   channel   dir   handshake            content
//   req_chan  in    valid/ready          cmd, data_byte, release_slot
//   rsp_chan  out   valid/ready          write command and frame status
//   csr_*     in    APB, pready tied 1   max_frame_len at byte address 0
//
// One transfer in and one result out per cycle unless rsp_chan stalls; each
// passes the input and result registers around the parser logic.
// A new transfer is taken while a result waits, as long as the result
// register can drain. Reset is synchronous and frees every slot.
// A stall on rsp_chan holds the result and backs up into req_chan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver (
   input  wire                               clock,
   input  wire                               reset,
   lpfr_req_if.sink                          req_chan,
   lpfr_rsp_if.source                        rsp_chan,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [lpfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [lpfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lpfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lpfr_pkg::*;

   logic [LEN_W-1:0]    max_frame_len;
   lpfr_slot_ctrl_type  slot_ctrl;
   lpfr_slot_stat_type  slot_stat;

   lpfr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_frame_len (max_frame_len)
   );

   lpfr_slots u_slots (
      .clock (clock),
      .reset (reset),
      .ctrl  (slot_ctrl),
      .stat  (slot_stat)
   );

   lpfr_core u_core (
      .clock         (clock),
      .reset         (reset),
      .max_frame_len (max_frame_len),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .slot_ctrl     (slot_ctrl),
      .slot_stat     (slot_stat)
   );

endmodule

`default_nettype wire

// ===== hdl/lpfr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Consistency of result flags seen on the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              wr_en,
   input wire                              byte_dropped,
   input wire                              frame_done,
   input wire [lpfr_pkg::LEN_W-1:0]        frame_size,
   input wire                              abort
);
   import lpfr_pkg::*;

   // done only on a stored byte, with a nonzero size
   a_done_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> wr_en && (frame_size != '0))
      else $error("frame_done without stored byte");

   a_size_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_done |-> frame_size == '0)
      else $error("frame_size set without frame_done");

   a_abort_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && abort |-> !wr_en && !byte_dropped && !frame_done)
      else $error("abort with payload activity");

   a_write_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(wr_en && byte_dropped))
      else $error("byte both written and dropped");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .wr_en        (rsp_chan.wr_en),
   .byte_dropped (rsp_chan.byte_dropped),
   .frame_done   (rsp_chan.frame_done),
   .frame_size   (rsp_chan.frame_size),
   .abort        (rsp_chan.abort)
);

`default_nettype wire
